>>> rtl/core/lfrs_pkg.sv
// Shared types, codes and constants for the logger file rotation sequencer.
// No dependencies; imported by every module of the block.

package lfrs_pkg;

    localparam int unsigned BUFFERS_PER_BLOCK_DEF = 4;

    localparam int unsigned SIZE_W  = 32;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned FIRST_W = 14;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned BCD_W   = 16;
    localparam int unsigned REM_W   = 10;

    localparam logic [FIRST_W-1:0] FIRST_MAX = 14'd9999;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_FILE_SIZE  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FILE_COUNT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_FIRST_NUM  = 2'd2;

    // event codes
    localparam logic [2:0] REQ_START     = 3'd0;
    localparam logic [2:0] REQ_REPORT    = 3'd1;
    localparam logic [2:0] REQ_WR_DONE   = 3'd2;
    localparam logic [2:0] REQ_FL_DONE   = 3'd3;
    localparam logic [2:0] REQ_OPEN_DONE = 3'd4;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_OPEN  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_WAIT_START = 3'd0,
        PH_IDLE       = 3'd1,
        PH_WRITING    = 3'd2,
        PH_FLUSHING   = 3'd3,
        PH_OPENING    = 3'd4,
        PH_ERROR      = 3'd5,
        PH_COMPLETE   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_CARD_OPEN = 3'd1,
        ERR_OVERLAP   = 3'd2,
        ERR_WRITE     = 3'd3,
        ERR_FLUSH     = 3'd4
    } err_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [COUNT_W-1:0] count;
        logic [3:0]         first_thou;
        logic [REM_W-1:0]   first_rem;
    } cfg_t;

    typedef struct packed {
        logic [2:0] req;
        logic [1:0] mask;
        logic       ok;
    } evt_t;

    typedef struct packed {
        cmd_t             command;
        logic             bsel;
        logic [BCD_W-1:0] name;
        phase_t           phase;
        err_t             error;
    } res_t;

    // clamp to 9999 and split off the thousands digit (reciprocal of 1000)
    function automatic logic [3+REM_W:0] first_split(input logic [FIRST_W-1:0] v);
        logic [FIRST_W-1:0] c;
        logic [27:0]        p;
        logic [3:0]         q;
        logic [FIRST_W-1:0] r;
        c = (v > FIRST_MAX) ? FIRST_MAX : v;
        p = 28'(c) * 28'd8389;
        q = p[26:23];
        r = c - FIRST_W'(q * 14'd1000);
        return {q, r[REM_W-1:0]};
    endfunction

    // remainder below 1000 to three BCD digits
    function automatic logic [11:0] low_bcd(input logic [REM_W-1:0] r);
        logic [15:0] ph;
        logic [3:0]  h;
        logic [6:0]  r2;
        logic [13:0] pt;
        logic [3:0]  t;
        logic [3:0]  u;
        ph = 16'(r) * 16'd41;
        h  = ph[15:12];
        r2 = 7'(r - REM_W'(h * 10'd100));
        pt = 14'(r2) * 14'd103;
        t  = pt[13:10];
        u  = 4'(r2 - 7'(t * 7'd10));
        return {h, t, u};
    endfunction

    function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] d);
        logic [BCD_W-1:0] r;
        logic             c;
        logic [4:0]       dg;
        r = '0;
        c = 1'b1;
        for (int i = 0; i < 4; i++) begin
            dg = 5'(d[4*i +: 4]) + 5'(c);
            if (dg >= 5'd10) begin
                dg = 5'd0;
                c  = 1'b1;
            end else begin
                c = 1'b0;
            end
            r[4*i +: 4] = dg[3:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/lfrs_cfg_regs.sv
// Configuration registers of the file rotation sequencer.
// Depends on lfrs_pkg; the first file number is stored clamped, thousands split off.

module lfrs_cfg_regs
    import lfrs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    output cfg_t              cfg
);

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic [3+REM_W:0]  split;

    assign split = first_split(cfg_wr_data[FIRST_W-1:0]);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_FILE_SIZE:  cfg_next.size  = cfg_wr_data[SIZE_W-1:0];
                CFG_FILE_COUNT: cfg_next.count = cfg_wr_data[COUNT_W-1:0];
                CFG_FIRST_NUM: begin
                    cfg_next.first_thou = split[3+REM_W:REM_W];
                    cfg_next.first_rem  = split[REM_W-1:0];
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.size       <= SIZE_W'(1);
            cfg_reg.count      <= COUNT_W'(1);
            cfg_reg.first_thou <= '0;
            cfg_reg.first_rem  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/lfrs_seq.sv
// Sequencer state and per-event update logic.
// Depends on lfrs_pkg; driven by the pipeline in the top level, one event per step.

module lfrs_seq
    import lfrs_pkg::*;
#(
    parameter int unsigned BUFFERS_PER_BLOCK = BUFFERS_PER_BLOCK_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic step,
    input  evt_t evt,
    input  cfg_t cfg,
    output res_t res
);

    localparam int unsigned BIB_W = $clog2(BUFFERS_PER_BLOCK + 1);

    phase_t             phase_reg,  phase_next;
    err_t               error_reg,  error_next;
    logic [BIB_W-1:0]   bib_reg,    bib_next;
    logic [SIZE_W-1:0]  blocks_reg, blocks_next;
    logic [COUNT_W-1:0] files_reg,  files_next;
    logic [BCD_W-1:0]   name_reg,   name_next;
    logic               act_reg,    act_next;

    logic [BIB_W-1:0]   bib_inc;
    logic [SIZE_W-1:0]  blocks_dec;
    logic [COUNT_W-1:0] files_dec;
    logic               bib_wrap;
    logic               blk_last;
    logic               file_more;
    cmd_t               cmd;
    logic               bsel;

    assign bib_inc    = bib_reg + BIB_W'(1);
    assign bib_wrap   = (bib_inc == BIB_W'(BUFFERS_PER_BLOCK));
    assign blocks_dec = blocks_reg - SIZE_W'(1);
    assign blk_last   = (blocks_dec == '0);
    assign files_dec  = files_reg - COUNT_W'(1);
    assign file_more  = (files_dec != '0);

    // next state
    always_comb begin
        phase_next  = phase_reg;
        error_next  = error_reg;
        bib_next    = bib_reg;
        blocks_next = blocks_reg;
        files_next  = files_reg;
        name_next   = name_reg;
        act_next    = act_reg;
        unique case (evt.req)
            REQ_START: begin
                if (phase_reg == PH_WAIT_START) begin
                    blocks_next = cfg.size;
                    files_next  = cfg.count;
                    name_next   = {cfg.first_thou, low_bcd(cfg.first_rem)};
                    bib_next    = '0;
                    phase_next  = PH_OPENING;
                end
            end
            REQ_REPORT: begin
                if (phase_reg == PH_IDLE) begin
                    if (evt.mask == 2'b11) begin
                        phase_next = PH_ERROR;
                        error_next = ERR_OVERLAP;
                    end else if (evt.mask != 2'b00) begin
                        act_next   = (evt.mask == 2'b10);
                        phase_next = PH_WRITING;
                    end
                end
            end
            REQ_WR_DONE: begin
                if (phase_reg == PH_WRITING) begin
                    if (!evt.ok) begin
                        phase_next = PH_ERROR;
                        error_next = ERR_WRITE;
                    end else if (bib_wrap) begin
                        bib_next   = '0;
                        phase_next = PH_FLUSHING;
                    end else begin
                        bib_next   = bib_inc;
                        phase_next = PH_IDLE;
                    end
                end
            end
            REQ_FL_DONE: begin
                if (phase_reg == PH_FLUSHING) begin
                    if (!evt.ok) begin
                        phase_next = PH_ERROR;
                        error_next = ERR_FLUSH;
                    end else if (blk_last) begin
                        blocks_next = cfg.size;
                        files_next  = files_dec;
                        if (file_more) begin
                            name_next  = bcd_inc(name_reg);
                            phase_next = PH_OPENING;
                        end else begin
                            phase_next = PH_COMPLETE;
                        end
                    end else begin
                        blocks_next = blocks_dec;
                        phase_next  = PH_IDLE;
                    end
                end
            end
            REQ_OPEN_DONE: begin
                if (phase_reg == PH_OPENING) begin
                    if (evt.ok) begin
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_ERROR;
                        error_next = ERR_CARD_OPEN;
                    end
                end
            end
            default: phase_next = phase_reg;
        endcase
    end

    // command out
    always_comb begin
        cmd  = CMD_NONE;
        bsel = 1'b0;
        unique case (evt.req)
            REQ_START: begin
                if (phase_reg == PH_WAIT_START) cmd = CMD_OPEN;
            end
            REQ_REPORT: begin
                if (phase_reg == PH_IDLE && evt.mask != 2'b11 && evt.mask != 2'b00) begin
                    cmd  = CMD_WRITE;
                    bsel = (evt.mask == 2'b10);
                end
            end
            REQ_WR_DONE: begin
                if (phase_reg == PH_WRITING && evt.ok && bib_wrap) cmd = CMD_FLUSH;
            end
            REQ_FL_DONE: begin
                if (phase_reg == PH_FLUSHING && evt.ok && blk_last && file_more) begin
                    cmd = CMD_OPEN;
                end
            end
            default: cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_WAIT_START;
            error_reg  <= ERR_NONE;
            bib_reg    <= '0;
            blocks_reg <= '0;
            files_reg  <= '0;
            name_reg   <= '0;
            act_reg    <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            error_reg  <= error_next;
            bib_reg    <= bib_next;
            blocks_reg <= blocks_next;
            files_reg  <= files_next;
            name_reg   <= name_next;
            act_reg    <= act_next;
        end
    end

    assign res.command = cmd;
    assign res.bsel    = bsel & act_next;
    assign res.name    = name_next;
    assign res.phase   = phase_next;
    assign res.error   = error_next;

endmodule

>>> rtl/core/logger_file_rotation_sequencer.sv
// Top level of the logger file rotation sequencer: input register, result register.
// Depends on lfrs_pkg, lfrs_cfg_regs and lfrs_seq.
//
//   channel  ports                                   direction
//   s_       s_valid s_ready s_req_type s_ready_mask s_op_ok   event in
//   m_       m_valid m_ready m_command m_buffer_select
//            m_file_name_bcd m_phase m_error_code        result out
//   cfg_     cfg_wr_en cfg_wr_index cfg_wr_data        register write
//
// One event per cycle while m_ does not stall; each event passes the input
// register, then the state update, into the result register that drives m_.
// Synchronous active-low reset clears the pipeline valids, sequencer state
// and registers (file size 1, file count 1, first number 0).
// An m_ stall holds the result; s_ready stays high while the input register
// is empty or can drain into the result register in the same cycle.

module logger_file_rotation_sequencer
    import lfrs_pkg::*;
#(
    parameter int unsigned BUFFERS_PER_BLOCK = BUFFERS_PER_BLOCK_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_req_type,
    input  logic [1:0]        s_ready_mask,
    input  logic              s_op_ok,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_command,
    output logic              m_buffer_select,
    output logic [BCD_W-1:0]  m_file_name_bcd,
    output logic [2:0]        m_phase,
    output logic [2:0]        m_error_code,
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]  cfg_wr_data
);

    cfg_t cfg;
    evt_t evt_reg;
    res_t res;
    res_t res_reg;
    logic in_vld_reg, in_vld_next;
    logic out_vld_reg, out_vld_next;
    logic advance;
    logic s_xfer;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    lfrs_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    lfrs_seq #(
        .BUFFERS_PER_BLOCK (BUFFERS_PER_BLOCK)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .evt     (evt_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_xfer) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            evt_reg.req  <= s_req_type;
            evt_reg.mask <= s_ready_mask;
            evt_reg.ok   <= s_op_ok;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_command       = res_reg.command;
    assign m_buffer_select = res_reg.bsel;
    assign m_file_name_bcd = res_reg.name;
    assign m_phase         = res_reg.phase;
    assign m_error_code    = res_reg.error;

    a_err_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_phase == PH_ERROR) == (m_error_code != ERR_NONE)))
        else $error("error code and error phase disagree");

    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_command == CMD_WRITE) |-> (m_phase == PH_WRITING))
        else $error("write command outside writing phase");

    a_open_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_command == CMD_OPEN) |-> (m_phase == PH_OPENING))
        else $error("open command outside opening phase");

    a_bsel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_command != CMD_WRITE) |-> !m_buffer_select)
        else $error("buffer select without write command");

endmodule

>>> bench/lfrs_rotation_checker.sv
// Checker for the logger file rotation sequencer: watches the event, result and
// register write ports, predicts every result from its own sequencer state, compares.
// Depends on lfrs_pkg for the codes and the result type.

module lfrs_rotation_checker
    import lfrs_pkg::*;
#(
    parameter int unsigned BUFS_PER_BLOCK = BUFFERS_PER_BLOCK_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [2:0]        s_req_type,
    input  logic [1:0]        s_ready_mask,
    input  logic              s_op_ok,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [1:0]        m_command,
    input  logic              m_buffer_select,
    input  logic [BCD_W-1:0]  m_file_name_bcd,
    input  logic [2:0]        m_phase,
    input  logic [2:0]        m_error_code,
    input  logic              cfg_wr_en,
    input  logic [CIDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    output int                errors,
    output int                pending,
    output int                results_seen
);

    logic [SIZE_W-1:0]  size_cfg;
    logic [COUNT_W-1:0] count_cfg;
    logic [FIRST_W-1:0] first_cfg;

    phase_t             seq_phase;
    err_t               seq_err;
    logic [7:0]         bufs_done;
    logic [SIZE_W-1:0]  blocks_to_go;
    logic [COUNT_W-1:0] files_to_go;
    logic [BCD_W-1:0]   file_name;
    logic               cur_buf;

    res_t predicted_results[$];

    function automatic logic [BCD_W-1:0] number_to_bcd(input logic [FIRST_W-1:0] n);
        int unsigned v;
        v = (n > 14'd9999) ? 9999 : n;
        return {4'(v / 1000), 4'((v / 100) % 10), 4'((v / 10) % 10), 4'(v % 10)};
    endfunction

    function automatic logic [BCD_W-1:0] next_file_name(input logic [BCD_W-1:0] d);
        logic [BCD_W-1:0] r;
        logic             carry;
        int               i;
        r     = d;
        carry = 1'b1;
        for (i = 0; i < 4; i++) begin
            if (carry) begin
                if (r[4*i +: 4] >= 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = r[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return r;
    endfunction

    task automatic advance_rotation(input logic [2:0] req, input logic [1:0] mask,
                                    input logic ok, output res_t r);
        cmd_t cmd;
        logic bsel;
        cmd  = CMD_NONE;
        bsel = 1'b0;
        case (req)
            REQ_START: begin
                if (seq_phase == PH_WAIT_START) begin
                    blocks_to_go = size_cfg;
                    files_to_go  = count_cfg;
                    file_name    = number_to_bcd(first_cfg);
                    bufs_done    = 8'd0;
                    cmd          = CMD_OPEN;
                    seq_phase    = PH_OPENING;
                end
            end
            REQ_REPORT: begin
                if (seq_phase == PH_IDLE) begin
                    if (mask == 2'b11) begin
                        seq_phase = PH_ERROR;
                        seq_err   = ERR_OVERLAP;
                    end else if (mask != 2'b00) begin
                        cur_buf   = (mask == 2'b10);
                        cmd       = CMD_WRITE;
                        bsel      = cur_buf;
                        seq_phase = PH_WRITING;
                    end
                end
            end
            REQ_WR_DONE: begin
                if (seq_phase == PH_WRITING) begin
                    if (!ok) begin
                        seq_phase = PH_ERROR;
                        seq_err   = ERR_WRITE;
                    end else begin
                        bufs_done = bufs_done + 8'd1;
                        if (bufs_done == 8'(BUFS_PER_BLOCK)) begin
                            bufs_done = 8'd0;
                            cmd       = CMD_FLUSH;
                            seq_phase = PH_FLUSHING;
                        end else begin
                            seq_phase = PH_IDLE;
                        end
                    end
                end
            end
            REQ_FL_DONE: begin
                if (seq_phase == PH_FLUSHING) begin
                    if (!ok) begin
                        seq_phase = PH_ERROR;
                        seq_err   = ERR_FLUSH;
                    end else begin
                        blocks_to_go = blocks_to_go - 1'b1;
                        if (blocks_to_go == '0) begin
                            blocks_to_go = size_cfg;
                            files_to_go  = files_to_go - 1'b1;
                            if (files_to_go != '0) begin
                                file_name = next_file_name(file_name);
                                cmd       = CMD_OPEN;
                                seq_phase = PH_OPENING;
                            end else begin
                                seq_phase = PH_COMPLETE;
                            end
                        end else begin
                            seq_phase = PH_IDLE;
                        end
                    end
                end
            end
            REQ_OPEN_DONE: begin
                if (seq_phase == PH_OPENING) begin
                    if (ok) begin
                        seq_phase = PH_IDLE;
                    end else begin
                        seq_phase = PH_ERROR;
                        seq_err   = ERR_CARD_OPEN;
                    end
                end
            end
            default: ;
        endcase
        r.command = cmd;
        r.bsel    = bsel;
        r.name    = file_name;
        r.phase   = seq_phase;
        r.error   = seq_err;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $time, msg);
        errors++;
    endtask

    task automatic compare_field(input string field, input logic [BCD_W-1:0] got,
                                 input logic [BCD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                      results_seen, field, got, want));
    endtask

    always @(posedge aclk) begin
        res_t want;
        res_t next_res;
        if (!aresetn) begin
            size_cfg     = 32'd1;
            count_cfg    = 16'd1;
            first_cfg    = '0;
            seq_phase    = PH_WAIT_START;
            seq_err      = ERR_NONE;
            bufs_done    = 8'd0;
            blocks_to_go = '0;
            files_to_go  = '0;
            file_name    = '0;
            cur_buf      = 1'b0;
            predicted_results.delete();
            errors       = 0;
            pending      = 0;
            results_seen = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_FILE_SIZE:  size_cfg  = cfg_wr_data[SIZE_W-1:0];
                    CFG_FILE_COUNT: count_cfg = cfg_wr_data[COUNT_W-1:0];
                    CFG_FIRST_NUM:  first_cfg = cfg_wr_data[FIRST_W-1:0];
                    default: ;
                endcase
            end
            // results first: a transfer accepted now cannot produce a result this edge
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                              results_seen));
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("command", 16'(m_command), 16'(want.command));
                    compare_field("buffer_select", 16'(m_buffer_select), 16'(want.bsel));
                    compare_field("file_name_bcd", m_file_name_bcd, want.name);
                    compare_field("phase", 16'(m_phase), 16'(want.phase));
                    compare_field("error_code", 16'(m_error_code), 16'(want.error));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                advance_rotation(s_req_type, s_ready_mask, s_op_ok, next_res);
                predicted_results.push_back(next_res);
            end
            pending = predicted_results.size();
        end
    end

endmodule

>>> bench/logger_file_rotation_sequencer_tb.sv
// Testbench top for the logger file rotation sequencer: clock, reset, event and
// register stimulus, result-side stalls and the verdict.
// Depends on lfrs_pkg, the sequencer RTL and lfrs_rotation_checker.

module logger_file_rotation_sequencer_tb;
    import lfrs_pkg::*;

    localparam int unsigned BUFS     = BUFFERS_PER_BLOCK_DEF;
    localparam int unsigned TARGET   = 1750;
    localparam int unsigned LIMIT    = 1000000;
    localparam int unsigned HOLD_AT  = 300;
    localparam int unsigned HOLD_LEN = 250;

    typedef enum int {
        END_OPEN_FAIL,
        END_OVERLAP,
        END_WRITE_FAIL,
        END_FLUSH_FAIL,
        END_COMPLETE
    } finish_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [2:0]        s_req_type;
    logic [1:0]        s_ready_mask;
    logic              s_op_ok;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_command;
    logic              m_buffer_select;
    logic [BCD_W-1:0]  m_file_name_bcd;
    logic [2:0]        m_phase;
    logic [2:0]        m_error_code;
    logic              cfg_wr_en;
    logic [CIDX_W-1:0] cfg_wr_index;
    logic [CFG_W-1:0]  cfg_wr_data;

    int errors;
    int pending;
    int results_seen;

    phase_t      flow_ph;
    finish_t     ending;
    int          sent;
    int          useful;
    int          ignored_sent;
    int          burst_left;
    int          files_closed;
    int          file_total;
    int          cycles;
    int unsigned cur_blocks;
    int unsigned next_blocks;
    bit          first_idle;

    always #5 aclk = ~aclk;

    logger_file_rotation_sequencer #(
        .BUFFERS_PER_BLOCK(BUFS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_ready_mask    (s_ready_mask),
        .s_op_ok         (s_op_ok),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_command       (m_command),
        .m_buffer_select (m_buffer_select),
        .m_file_name_bcd (m_file_name_bcd),
        .m_phase         (m_phase),
        .m_error_code    (m_error_code),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data)
    );

    lfrs_rotation_checker #(
        .BUFS_PER_BLOCK(BUFS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_ready_mask    (s_ready_mask),
        .s_op_ok         (s_op_ok),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_command       (m_command),
        .m_buffer_select (m_buffer_select),
        .m_file_name_bcd (m_file_name_bcd),
        .m_phase         (m_phase),
        .m_error_code    (m_error_code),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .errors          (errors),
        .pending         (pending),
        .results_seen    (results_seen)
    );

    function automatic bit ignored_in(input phase_t p, input logic [2:0] r,
                                      input logic [1:0] m);
        case (r)
            REQ_START:     return p != PH_WAIT_START;
            REQ_REPORT:    return p != PH_IDLE || m == 2'b00;
            REQ_WR_DONE:   return p != PH_WRITING;
            REQ_FL_DONE:   return p != PH_FLUSHING;
            REQ_OPEN_DONE: return p != PH_OPENING;
            default:       return 1'b1;
        endcase
    endfunction

    function automatic int unsigned pick_size();
        if (ending == END_COMPLETE)
            return 190 / file_total + $urandom_range(0, 2);
        return ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 4);
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_event(input logic [2:0] r, input logic [1:0] m, input logic o);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: gap = 0;
                6:                gap = $urandom_range(10, 40);
                default:          gap = $urandom_range(1, 4);
            endcase
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_valid      = 1'b1;
        s_req_type   = r;
        s_ready_mask = m;
        s_op_ok      = o;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        sent++;
    endtask

    task automatic send_ignored(input logic [2:0] r, input logic [1:0] m, input logic o);
        send_event(r, m, o);
        ignored_sent++;
    endtask

    task automatic send_noise();
        logic [2:0] r;
        logic [1:0] m;
        r = 3'($urandom_range(0, 7));
        m = 2'($urandom_range(0, 3));
        while (!ignored_in(flow_ph, r, m)) begin
            r = 3'($urandom_range(0, 7));
            m = 2'($urandom_range(0, 3));
        end
        send_ignored(r, m, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_useful(input logic [2:0] r, input logic [1:0] m, input logic o);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 2)) send_noise();
        send_event(r, m, o);
        useful++;
    endtask

    task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = data;
        @(negedge aclk);
        cfg_wr_en    = 1'b0;
    endtask

    // registers change only with nothing in flight
    task automatic reconfigure();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_FILE_SIZE, 32'hFFFF_FFFF);
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_FILE_COUNT, CFG_W'($urandom_range(1, 65535)));
        if ($urandom_range(0, 3) == 0)
            cfg_write(CFG_FIRST_NUM, CFG_W'($urandom_range(0, 16383)));
        next_blocks = pick_size();
        cfg_write(CFG_FILE_SIZE, CFG_W'(next_blocks));
    endtask

    function automatic bit end_now(input finish_t kind);
        return ending == kind && useful >= TARGET;
    endfunction

    task automatic run_flow();
        bit          finished;
        int unsigned blk;
        int unsigned w;
        logic [1:0]  m;
        finished = 1'b0;
        while (!finished) begin
            if (end_now(END_OPEN_FAIL)) begin
                send_useful(REQ_OPEN_DONE, 2'($urandom_range(0, 3)), 1'b0);
                flow_ph  = PH_ERROR;
                finished = 1'b1;
            end else begin
                send_useful(REQ_OPEN_DONE, 2'($urandom_range(0, 3)), 1'b1);
                flow_ph = PH_IDLE;
                if (first_idle) begin
                    first_idle = 1'b0;
                    send_ignored(REQ_REPORT, 2'b00, 1'b1);
                    send_ignored(REQ_FL_DONE, 2'b11, 1'b1);
                    send_ignored(REQ_OPEN_DONE, 2'b01, 1'b1);
                    send_ignored(REQ_START, 2'b10, 1'b0);
                    reconfigure();
                end else if ($urandom_range(0, 2) == 0) begin
                    reconfigure();
                end
                blk = 0;
                while (!finished && blk < cur_blocks) begin
                    for (w = 0; w < BUFS && !finished; w++) begin
                        if (end_now(END_OVERLAP)) begin
                            send_useful(REQ_REPORT, 2'b11, 1'($urandom_range(0, 1)));
                            flow_ph  = PH_ERROR;
                            finished = 1'b1;
                        end else begin
                            m = ($urandom_range(0, 1) == 0) ? 2'b01 : 2'b10;
                            send_useful(REQ_REPORT, m, 1'($urandom_range(0, 1)));
                            flow_ph = PH_WRITING;
                            if (end_now(END_WRITE_FAIL)) begin
                                send_useful(REQ_WR_DONE, 2'($urandom_range(0, 3)), 1'b0);
                                flow_ph  = PH_ERROR;
                                finished = 1'b1;
                            end else begin
                                send_useful(REQ_WR_DONE, 2'($urandom_range(0, 3)), 1'b1);
                                flow_ph = (w == BUFS - 1) ? PH_FLUSHING : PH_IDLE;
                            end
                        end
                    end
                    if (!finished) begin
                        if (end_now(END_FLUSH_FAIL)) begin
                            send_useful(REQ_FL_DONE, 2'($urandom_range(0, 3)), 1'b0);
                            flow_ph  = PH_ERROR;
                            finished = 1'b1;
                        end else begin
                            send_useful(REQ_FL_DONE, 2'($urandom_range(0, 3)), 1'b1);
                            flow_ph = PH_IDLE;
                            blk++;
                        end
                    end
                end
                if (!finished) begin
                    files_closed++;
                    if (ending == END_COMPLETE && files_closed == file_total) begin
                        flow_ph  = PH_COMPLETE;
                        finished = 1'b1;
                    end else begin
                        flow_ph    = PH_OPENING;
                        cur_blocks = next_blocks;
                    end
                end
            end
        end
    endtask

    // result side: changing stall patterns, one long hold-off while events keep coming
    initial begin
        int mode;
        int stretch;
        int tick;
        bit held;
        m_ready = 1'b0;
        held    = 1'b0;
        tick    = 0;
        @(posedge aresetn);
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 80);
            repeat (stretch) begin
                @(negedge aclk);
                if (!held && sent >= HOLD_AT) begin
                    held    = 1'b1;
                    m_ready = 1'b0;
                    repeat (HOLD_LEN) @(negedge aclk);
                end
                tick++;
                case (mode)
                    0:       m_ready = 1'b1;
                    1:       m_ready = 1'($urandom_range(0, 1));
                    2:       m_ready = ($urandom_range(0, 3) == 0);
                    default: m_ready = (tick % 3 != 0);
                endcase
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("logger_file_rotation_sequencer: mismatch");
        $finish;
    end

    initial begin
        int    r;
        int    first_num;
        string ending_words;
        s_valid      = 1'b0;
        s_req_type   = REQ_START;
        s_ready_mask = 2'b00;
        s_op_ok      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = CFG_FILE_SIZE;
        cfg_wr_data  = '0;
        aresetn      = 1'b0;
        sent         = 0;
        useful       = 0;
        ignored_sent = 0;
        burst_left   = 0;
        files_closed = 0;
        first_idle   = 1'b1;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        ending     = finish_t'($urandom_range(0, 4));
        file_total = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
        case ($urandom_range(0, 3))
            0, 1:    first_num = 16383;
            2:       first_num = 9999;
            default: first_num = $urandom_range(0, 16383);
        endcase

        cfg_write(CFG_FILE_SIZE, 32'hFFFF_FFFF);
        cfg_write(CFG_FILE_COUNT, 32'd1);
        cfg_write(CFG_FIRST_NUM, 32'd0);
        cfg_write(CFG_FIRST_NUM, CFG_W'(first_num));
        cfg_write(CFG_FILE_COUNT, (ending == END_COMPLETE) ? CFG_W'(file_total) : 32'd65535);
        cur_blocks  = pick_size();
        next_blocks = cur_blocks;
        cfg_write(CFG_FILE_SIZE, CFG_W'(cur_blocks));

        // out-of-phase and unknown events before start, the start, then out-of-phase events
        flow_ph = PH_WAIT_START;
        send_ignored(REQ_REPORT, 2'b11, 1'b1);
        send_ignored(REQ_WR_DONE, 2'b00, 1'b0);
        send_ignored(REQ_FL_DONE, 2'b01, 1'b1);
        send_ignored(REQ_OPEN_DONE, 2'b10, 1'b1);
        for (r = int'(REQ_OPEN_DONE) + 1; r < 8; r++)
            send_ignored(3'(r), 2'(r), 1'(r));
        send_useful(REQ_START, 2'b10, 1'b0);
        flow_ph = PH_OPENING;
        send_ignored(REQ_START, 2'b01, 1'b1);
        send_ignored(REQ_REPORT, 2'b01, 1'b0);

        run_flow();

        // everything after an error or completion must be ignored
        repeat (8) send_noise();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        case (ending)
            END_OPEN_FAIL:  ending_words = "failed open of a later file";
            END_OVERLAP:    ending_words = "buffer overlap";
            END_WRITE_FAIL: ending_words = "failed write";
            END_FLUSH_FAIL: ending_words = "failed flush";
            default:        ending_words = "all files filled";
        endcase
        $display("covered %0d event transfers (%0d out of phase or unknown), %0d files closed",
                 sent, ignored_sent, files_closed);
        $display("ended on %s, %0d results checked", ending_words, results_seen);
        if (errors == 0) begin
            $display("logger_file_rotation_sequencer: match");
        end else begin
            $display("logger_file_rotation_sequencer: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/lfrs_pkg.sv
rtl/core/lfrs_cfg_regs.sv
rtl/core/lfrs_seq.sv
rtl/core/logger_file_rotation_sequencer.sv
bench/lfrs_rotation_checker.sv
bench/logger_file_rotation_sequencer_tb.sv
